>>> rtl/afm_pkg.sv
// afm_pkg: shared constants and codes for the fuel map autotuner
// depends on nothing; used by afm_div, afr_fuel_map_autotune_core and tb
`default_nettype none
package afm_pkg;

  localparam int MAP_SIZE_DEF       = 20;
  localparam int TOTAL_REQUESTS_DEF = 8;

  localparam logic [15:0] TARGET_AFR_RST        = 16'd1470;
  localparam logic [15:0] DEV_FLOOR_RST         = 16'd30;
  localparam logic [15:0] MIN_CELL_SAMPLES_RST  = 16'd5;
  localparam logic [15:0] ATTEMPT_INTERVAL_RST  = 16'd50;
  localparam logic [8:0]  MIN_CELLS_CHANGED_RST = 9'd1;

  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_TARGET_AFR        = 3'd0,
    REG_DEV_FLOOR         = 3'd1,
    REG_MIN_CELL_SAMPLES  = 3'd2,
    REG_ATTEMPT_INTERVAL  = 3'd3,
    REG_MIN_CELLS_CHANGED = 3'd4
  } reg_index_t;

endpackage
`default_nettype wire

>>> rtl/afm_div.sv
// afm_div: restoring divider, one quotient bit a cycle, saturates at 16 bits
// depends on afm_pkg
`default_nettype none
module afm_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [afm_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [afm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  done,
  output logic [15:0]                           quotient
);

  logic                            busy;
  logic [4:0]                      step;
  logic [afm_pkg::DIVIDEND_W-1:0]  rem;
  logic [afm_pkg::DIVIDEND_W-1:0]  dsh;
  logic [16:0]                     qbits;
  logic                            ge;
  logic [16:0]                     qbits_next;

  assign ge         = rem >= dsh;
  assign qbits_next = {qbits[15:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= 5'd16;
        rem   <= dividend;
        dsh   <= {divisor, 16'b0};
        qbits <= 17'd0;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh   <= dsh >> 1;
        qbits <= qbits_next;
        if (step == 5'd0) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          // top quotient bit set means the result is at least 65536
          quotient <= qbits_next[16] ? 16'hFFFF : qbits_next[15:0];
        end else begin
          step <= step - 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/afr_fuel_map_autotune_core.sv
// afr_fuel_map_autotune_core: closed-loop fuel table tuner, top level
// depends on afm_pkg and afm_div
// flow: load, sample and read requests step through issue, operate and done
// states; the result is registered on leaving done, which out_stall can hold;
// recalculating ticks walk every cell through read, multiply and check states,
// waiting on the 17-step divider for each corrected cell with a nonzero goal;
// map sync ticks walk every cell; one request is worked on at a time
// reset: a clearing pass over every cell zeroes the sample log memory,
// in_stall is high until it finishes; config writes are taken anytime
`default_nettype none
module afr_fuel_map_autotune_core #(
  parameter int MAP_SIZE       = afm_pkg::MAP_SIZE_DEF,
  parameter int TOTAL_REQUESTS = afm_pkg::TOTAL_REQUESTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [4:0]  load_index,
  input  wire logic [4:0]  rpm_index,
  input  wire logic [15:0] fuel_value,
  input  wire logic [15:0] afr,
  input  wire logic [3:0]  max_requests,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic             send_packet,
  output logic [3:0]       write_request,
  output logic [8:0]       cells_changed,
  output logic [15:0]      current_fuel,
  output logic [15:0]      new_fuel,
  output logic [15:0]      write_count
);

  localparam int CELLS = MAP_SIZE * MAP_SIZE;
  localparam int CW    = $clog2(CELLS);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_ISSUE  = 11'b00000000100,
    S_OP     = 11'b00000001000,
    S_SC_RD  = 11'b00000010000,
    S_SC_MUL = 11'b00000100000,
    S_SC_CHK = 11'b00001000000,
    S_SC_DIV = 11'b00010000000,
    S_SY_RD  = 11'b00100000000,
    S_SY_EV  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // config registers
  logic [15:0] target_afr, dev_floor, min_cell_samples, attempt_interval;
  logic [8:0]  min_cells_changed;

  // control state
  logic [15:0] sample_phase;
  logic [3:0]  req;
  logic [15:0] cycles_started;
  logic [CW-1:0] idx;
  logic [8:0]  changed;

  // latched request
  logic [1:0]  func_r;
  logic [4:0]  load_r, rpm_r;
  logic [15:0] fuel_r, afr_r;
  logic [3:0]  maxr_r;

  // pending result
  logic        res_status, res_send;
  logic [8:0]  res_changed;
  logic [15:0] res_cur, res_new;

  // memories: both fuel maps side by side {current, new} and the sample log {count, sum}
  logic [31:0] map_mem [CELLS];
  logic [47:0] log_mem [CELLS];
  logic [31:0] map_q;
  logic [15:0] cur_q, new_q;
  logic [47:0] log_q;

  logic [CW-1:0] cell_r, rd_addr, wr_addr;
  logic        bad_r;
  logic        map_we, log_we;
  logic [31:0] map_wd;
  logic [47:0] log_wd;

  // scan datapath
  logic [31:0] goal_r, ndel_r;
  logic [47:0] prod_r;
  logic [15:0] cnt_q;
  logic [31:0] sum_q, dev;
  logic        eligible, correct;
  logic        div_start, div_done;
  logic [15:0] div_q;
  logic        scan_adv, scan_wr;
  logic [15:0] scan_val;
  logic [9:0]  changed_sum;
  logic [8:0]  changed_next;

  logic [15:0] interval;
  logic [16:0] phase_inc;
  logic [3:0]  maxr_clamp;
  logic        load_out;

  assign cnt_q = log_q[47:32];
  assign sum_q = log_q[31:0];
  assign cur_q = map_q[31:16];
  assign new_q = map_q[15:0];

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  assign cell_r = CW'(32'(load_r) * MAP_SIZE + 32'(rpm_r));
  assign bad_r  = (32'(load_r) >= 32'(MAP_SIZE)) || (32'(rpm_r) >= 32'(MAP_SIZE));

  assign interval   = (attempt_interval == 16'd0) ? 16'd1 : attempt_interval;
  assign phase_inc  = {1'b0, sample_phase} + 17'd1;
  assign maxr_clamp = (32'(maxr_r) > 32'(TOTAL_REQUESTS)) ? 4'(TOTAL_REQUESTS) : maxr_r;

  // deviation of the logged sum from count times target
  assign dev      = (sum_q >= goal_r) ? (sum_q - goal_r) : (goal_r - sum_q);
  assign eligible = (cnt_q >= min_cell_samples) && (cnt_q != 16'd0);
  assign correct  = eligible && (dev >= ndel_r);

  assign div_start = (state == S_SC_CHK) && correct && (goal_r != 32'd0);

  always_comb begin
    scan_adv = 1'b0;
    scan_wr  = 1'b0;
    scan_val = div_q;
    if (state == S_SC_CHK && !div_start) begin
      scan_adv = 1'b1;
      scan_wr  = correct;
      // zero target: any nonzero product saturates
      scan_val = (prod_r != 48'd0) ? 16'hFFFF : 16'd0;
    end else if (state == S_SC_DIV && div_done) begin
      scan_adv = 1'b1;
      scan_wr  = 1'b1;
    end
  end

  assign changed_sum  = {1'b0, changed} + {9'd0, scan_wr};
  assign changed_next = changed_sum[9] ? 9'd511 : changed_sum[8:0];

  // memory port control
  assign rd_addr = (state == S_IDLE || state == S_ISSUE || state == S_OP) ? cell_r : idx;

  always_comb begin
    map_we  = 1'b0;
    log_we  = 1'b0;
    wr_addr = idx;
    map_wd  = {fuel_r, fuel_r};
    log_wd  = 48'd0;
    unique case (state)
      S_CLEAR: begin
        log_we = 1'b1;
      end
      S_OP: begin
        wr_addr = cell_r;
        if (!bad_r && func_r == afm_pkg::FUNC_LOAD) begin
          map_we = 1'b1;
        end
        if (!bad_r && func_r == afm_pkg::FUNC_SAMPLE && cnt_q != 16'hFFFF) begin
          log_we = 1'b1;
          log_wd = {cnt_q + 16'd1, sum_q + {16'd0, afr_r}};
        end
      end
      S_SC_CHK, S_SC_DIV: begin
        // only the new half changes, the current half is written back as read
        map_we = scan_wr;
        map_wd = {cur_q, scan_val};
      end
      S_SY_EV: begin
        // copy the new value over and drop the cell's log if it holds min_cell_samples or more
        if (new_q != cur_q) begin
          map_we = 1'b1;
          map_wd = {new_q, new_q};
          log_we = (cnt_q >= min_cell_samples);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[wr_addr] <= map_wd;
    end
    map_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[wr_addr] <= log_wd;
    end
    log_q <= log_mem[rd_addr];
  end

  afm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (goal_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_afr        <= afm_pkg::TARGET_AFR_RST;
      dev_floor         <= afm_pkg::DEV_FLOOR_RST;
      min_cell_samples  <= afm_pkg::MIN_CELL_SAMPLES_RST;
      attempt_interval  <= afm_pkg::ATTEMPT_INTERVAL_RST;
      min_cells_changed <= afm_pkg::MIN_CELLS_CHANGED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afm_pkg::REG_TARGET_AFR:        target_afr        <= cfg_data;
        afm_pkg::REG_DEV_FLOOR:         dev_floor         <= cfg_data;
        afm_pkg::REG_MIN_CELL_SAMPLES:  min_cell_samples  <= cfg_data;
        afm_pkg::REG_ATTEMPT_INTERVAL:  attempt_interval  <= cfg_data;
        afm_pkg::REG_MIN_CELLS_CHANGED: min_cells_changed <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // request latch and product registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r <= func;
      load_r <= load_index;
      rpm_r  <= rpm_index;
      fuel_r <= fuel_value;
      afr_r  <= afr;
      maxr_r <= max_requests;
    end
    if (state == S_SC_MUL) begin
      goal_r <= 32'(cnt_q) * 32'(target_afr);
      ndel_r <= 32'(cnt_q) * 32'(dev_floor);
      prod_r <= 48'(cur_q) * 48'(sum_q);
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      idx            <= '0;
      sample_phase   <= 16'd0;
      req            <= 4'd0;
      cycles_started <= 16'd0;
      changed        <= 9'd0;
      res_status     <= 1'b0;
      res_send       <= 1'b0;
      res_changed    <= 9'd0;
      res_cur        <= 16'd0;
      res_new        <= 16'd0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_CELL) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_status  <= 1'b0;
            res_send    <= 1'b0;
            res_changed <= 9'd0;
            res_cur     <= 16'd0;
            res_new     <= 16'd0;
            state       <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_OP;
        end
        S_OP: begin
          state <= S_DONE;
          if (func_r == afm_pkg::FUNC_TICK) begin
            idx     <= '0;
            changed <= 9'd0;
            if (req == 4'd0) begin
              if (sample_phase == 16'd0 || interval == 16'd1) begin
                state <= S_SC_RD;
              end
            end else if (req >= maxr_clamp) begin
              state <= S_SY_RD;
            end else begin
              req      <= req + 4'd1;
              res_send <= 1'b1;
            end
          end else if (bad_r) begin
            res_status <= 1'b1;
          end else if (func_r == afm_pkg::FUNC_LOAD) begin
            res_cur <= fuel_r;
            res_new <= fuel_r;
          end else if (func_r == afm_pkg::FUNC_SAMPLE) begin
            sample_phase <= (phase_inc >= {1'b0, interval}) ? 16'd0 : phase_inc[15:0];
          end else begin
            res_cur <= cur_q;
            res_new <= new_q;
          end
        end
        S_SC_RD: begin
          state <= S_SC_MUL;
        end
        S_SC_MUL: begin
          state <= S_SC_CHK;
        end
        S_SC_CHK, S_SC_DIV: begin
          if (div_start) begin
            state <= S_SC_DIV;
          end else if (scan_adv) begin
            changed <= changed_next;
            if (idx == LAST_CELL) begin
              res_changed <= changed_next;
              if (changed_next >= min_cells_changed) begin
                req            <= 4'd1;
                cycles_started <= cycles_started + 16'd1;
                res_send       <= 1'b1;
              end
              state <= S_DONE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_SC_RD;
            end
          end
        end
        S_SY_RD: begin
          state <= S_SY_EV;
        end
        S_SY_EV: begin
          if (idx == LAST_CELL) begin
            req   <= 4'd0;
            state <= S_DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SY_RD;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register: holds a finished result while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
    end
    if (load_out) begin
      status        <= res_status;
      send_packet   <= res_send;
      write_request <= req;
      cells_changed <= res_changed;
      current_fuel  <= res_cur;
      new_fuel      <= res_new;
      write_count   <= cycles_started;
    end
  end

  // no result leaves while the log memory is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during clearing pass");

  // request number stays within the write cycle length
  a_req_range: assert property (@(posedge clk) disable iff (rst)
    32'(req) <= TOTAL_REQUESTS)
    else $error("write request number out of range");

  // divider finishes only while the scan waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_SC_DIV))
    else $error("divider result outside a scan");

endmodule
`default_nettype wire

>>> verif/tb.sv
// tb: self-checking testbench for afr_fuel_map_autotune_core
// depends on afm_pkg and the rtl of the tuner; drives requests, predicts and compares results
`timescale 1ns / 1ps
module tb;

  localparam int MSIZE = afm_pkg::MAP_SIZE_DEF;
  localparam int NCELL = MSIZE * MSIZE;
  localparam int NREQ  = afm_pkg::TOTAL_REQUESTS_DEF;

  typedef struct {
    afm_pkg::func_t fn;
    logic [4:0]  li;
    logic [4:0]  ri;
    logic [15:0] fuel;
    logic [15:0] afr;
    logic [3:0]  maxr;
  } req_t;

  typedef struct {
    logic        status;
    logic        send;
    logic [3:0]  wreq;
    logic [8:0]  changed;
    logic [15:0] cur;
    logic [15:0] nxt;
    logic [15:0] wcount;
  } res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [4:0]  load_index = '0;
  logic [4:0]  rpm_index = '0;
  logic [15:0] fuel_value = '0;
  logic [15:0] afr = '0;
  logic [3:0]  max_requests = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        status;
  logic        send_packet;
  logic [3:0]  write_request;
  logic [8:0]  cells_changed;
  logic [15:0] current_fuel;
  logic [15:0] new_fuel;
  logic [15:0] write_count;

  afr_fuel_map_autotune_core u_dut (.*);

  always #10 clk = ~clk;

  // predicted copy of the tuner state
  logic [15:0] cur_map [NCELL];
  logic [15:0] nxt_map [NCELL];
  logic [31:0] afr_sum [NCELL];
  logic [15:0] afr_cnt [NCELL];
  logic [15:0] phase_cnt;
  logic [3:0]  req_num;
  logic [15:0] cycles_run;
  logic [15:0] tgt_afr, min_dev, min_samp, interval;
  logic [8:0]  min_changed;

  req_t pending_reqs[$];
  res_t expected_res[$];
  req_t on_bus;
  int   errors = 0;
  int   idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both lightly
  logic hold_start = 0, hold_done = 0;
  int   hold_cnt = 0;

  function automatic int recalc_cells();
    int n_chg;
    longint unsigned n, s, goal, dev, q, prod;
    n_chg = 0;
    for (int c = 0; c < NCELL; c++) begin
      n = afr_cnt[c];
      s = afr_sum[c];
      if (n < min_samp || n == 0) continue;
      goal = n * tgt_afr;
      dev = (s >= goal) ? s - goal : goal - s;
      if (dev < n * min_dev) continue;
      prod = longint'(cur_map[c]) * s;
      if (goal == 0) q = (prod != 0) ? 65535 : 0;
      else q = prod / goal;
      if (q > 65535) q = 65535;
      nxt_map[c] = q[15:0];
      n_chg++;
    end
    return (n_chg > 511) ? 511 : n_chg;
  endfunction

  // commit new map into current map at the end of a write cycle
  function automatic void sync_maps();
    for (int c = 0; c < NCELL; c++)
      if (nxt_map[c] != cur_map[c]) begin
        cur_map[c] = nxt_map[c];
        if (afr_cnt[c] >= min_samp) begin
          afr_sum[c] = 0;
          afr_cnt[c] = 0;
        end
      end
  endfunction

  function automatic res_t tune_step(req_t r);
    res_t o;
    logic bad;
    int addr, iv, mr, ph, chg;
    o = '{default: '0};
    bad = (r.li >= MSIZE) || (r.ri >= MSIZE);
    addr = bad ? 0 : r.li * MSIZE + r.ri;
    iv = (interval == 0) ? 1 : interval;
    if (r.fn == afm_pkg::FUNC_TICK) begin
      mr = (r.maxr > NREQ) ? NREQ : r.maxr;
      if (req_num == 0) begin
        if (phase_cnt == 0 || iv == 1) begin
          chg = recalc_cells();
          o.changed = 9'(chg);
          if (chg >= min_changed) begin
            req_num = 4'd1;
            cycles_run++;
            o.send = 1;
          end
        end
      end else if (req_num >= mr) begin
        sync_maps();
        req_num = 4'd0;
      end else begin
        req_num++;
        o.send = 1;
      end
    end else if (bad) begin
      o.status = 1;
    end else if (r.fn == afm_pkg::FUNC_LOAD) begin
      cur_map[addr] = r.fuel;
      nxt_map[addr] = r.fuel;
      o.cur = r.fuel;
      o.nxt = r.fuel;
    end else if (r.fn == afm_pkg::FUNC_SAMPLE) begin
      ph = phase_cnt + 1;
      if (afr_cnt[addr] != 16'hFFFF) begin
        afr_sum[addr] += r.afr;
        afr_cnt[addr]++;
      end
      phase_cnt = (ph >= iv) ? 16'd0 : 16'(ph);
    end else begin
      o.cur = cur_map[addr];
      o.nxt = nxt_map[addr];
    end
    o.wreq = req_num;
    o.wcount = cycles_run;
    return o;
  endfunction

  function automatic bit idle_now(bit rx_side);
    case (idle_mode)
      1: return !rx_side && $urandom_range(99) < 85;
      2: return rx_side && $urandom_range(99) < 85;
      3: return $urandom_range(99) < 10;
      default: return 0;
    endcase
  endfunction

  // request driver: hold while stalled, predict on accept, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_res.push_back(tune_step(on_bus));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !idle_now(0)) begin
        on_bus = pending_reqs[0];
        func <= on_bus.fn;
        load_index <= on_bus.li;
        rpm_index <= on_bus.ri;
        fuel_value <= on_bus.fuel;
        afr <= on_bus.afr;
        max_requests <= on_bus.maxr;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  function automatic void cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_res.pop_front();
        cmp("status", e.status, status);
        cmp("send_packet", e.send, send_packet);
        cmp("write_request", e.wreq, write_request);
        cmp("cells_changed", e.changed, cells_changed);
        cmp("current_fuel", e.cur, current_fuel);
        cmp("new_fuel", e.nxt, new_fuel);
        cmp("write_count", e.wcount, write_count);
      end
    end
    out_stall <= (hold_cnt != 0) || idle_now(1);
  end

  // long receiver hold-off so the pipeline backs up into in_stall
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_start && !hold_done) begin
      hold_cnt <= 400;
      hold_done <= 1;
    end
  end

  task automatic write_reg(afm_pkg::reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      afm_pkg::REG_TARGET_AFR:       tgt_afr = val;
      afm_pkg::REG_DEV_FLOOR:        min_dev = val;
      afm_pkg::REG_MIN_CELL_SAMPLES: min_samp = val;
      afm_pkg::REG_ATTEMPT_INTERVAL: interval = val;
      default:                       min_changed = val[8:0];
    endcase
  endtask

  task automatic set_regs(int t, int d, int s, int i, int m);
    write_reg(afm_pkg::REG_TARGET_AFR, 16'(t));
    write_reg(afm_pkg::REG_DEV_FLOOR, 16'(d));
    write_reg(afm_pkg::REG_MIN_CELL_SAMPLES, 16'(s));
    write_reg(afm_pkg::REG_ATTEMPT_INTERVAL, 16'(i));
    write_reg(afm_pkg::REG_MIN_CELLS_CHANGED, 16'(m));
  endtask

  task automatic push(afm_pkg::func_t f, int li, int ri, int fuel, int a, int mr);
    req_t r;
    r.fn = f; r.li = 5'(li); r.ri = 5'(ri); r.fuel = 16'(fuel); r.afr = 16'(a);
    r.maxr = 4'(mr);
    pending_reqs.push_back(r);
  endtask

  // random request: samples mostly into a few hot cells so counts build up
  task automatic push_random();
    int sel, li, ri, a;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 10) begin
      li = $urandom_range(31);
      ri = $urandom_range(31);
    end else if ($urandom_range(99) < 70) begin
      li = $urandom_range(2);
      ri = $urandom_range(2);
    end else begin
      li = $urandom_range(MSIZE - 1);
      ri = $urandom_range(MSIZE - 1);
    end
    a = ($urandom_range(3) == 0) ? $urandom_range(65535) : tgt_afr + $urandom_range(400) - 200;
    if (sel < 12) push(afm_pkg::FUNC_LOAD, li, ri, $urandom_range(65535), $urandom_range(65535),
                       $urandom_range(15));
    else if (sel < 72) push(afm_pkg::FUNC_SAMPLE, li, ri, $urandom_range(65535), a,
                            $urandom_range(15));
    else if (sel < 78) push(afm_pkg::FUNC_TICK, $urandom_range(31), $urandom_range(31),
                            $urandom_range(65535), $urandom_range(65535), $urandom_range(15));
    else push(afm_pkg::FUNC_READ, li, ri, $urandom_range(65535), $urandom_range(65535),
              $urandom_range(15));
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_res.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int c = 0; c < NCELL; c++) begin
      cur_map[c] = 16'd0; nxt_map[c] = 16'd0; afr_sum[c] = 32'd0; afr_cnt[c] = 16'd0;
    end
    phase_cnt = 16'd0; req_num = 4'd0; cycles_run = 16'd0;
    tgt_afr = afm_pkg::TARGET_AFR_RST; min_dev = afm_pkg::DEV_FLOOR_RST;
    min_samp = afm_pkg::MIN_CELL_SAMPLES_RST; interval = afm_pkg::ATTEMPT_INTERVAL_RST;
    min_changed = afm_pkg::MIN_CELLS_CHANGED_RST;
    repeat (11) @(posedge clk);
    rst <= 0;

    // fill every cell of both maps so no later access sees an unwritten entry
    for (int c = 0; c < NCELL; c++)
      push(afm_pkg::FUNC_LOAD, c / MSIZE, c % MSIZE, $urandom_range(65535), 0, 0);
    // directed: field extremes, out-of-range indices, every function
    push(afm_pkg::FUNC_LOAD, 0, 0, 0, 0, 0);
    push(afm_pkg::FUNC_LOAD, MSIZE - 1, MSIZE - 1, 65535, 65535, 15);
    push(afm_pkg::FUNC_LOAD, MSIZE, 0, 1234, 0, 0);
    push(afm_pkg::FUNC_LOAD, 0, 31, 1234, 0, 0);
    push(afm_pkg::FUNC_READ, 0, 0, 0, 0, 0);
    push(afm_pkg::FUNC_READ, MSIZE - 1, MSIZE - 1, 0, 0, 0);
    push(afm_pkg::FUNC_READ, 31, 31, 0, 0, 0);
    push(afm_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0);
    push(afm_pkg::FUNC_SAMPLE, 0, 0, 0, 65535, 0);
    push(afm_pkg::FUNC_SAMPLE, 25, 3, 0, 1500, 0);
    push(afm_pkg::FUNC_TICK, 31, 31, 0, 0, 15);
    push(afm_pkg::FUNC_TICK, 0, 0, 0, 0, 0);
    drain();

    // every tick attempts, small sample counts: frequent write cycles
    set_regs(1470, 30, 2, 1, 1);
    push(afm_pkg::FUNC_LOAD, 1, 1, 20000, 0, 0);
    for (int k = 0; k < 3; k++) push(afm_pkg::FUNC_SAMPLE, 1, 1, 0, 1800, 0);
    push(afm_pkg::FUNC_TICK, 0, 0, 0, 0, 15);
    push(afm_pkg::FUNC_TICK, 0, 0, 0, 0, 0);  // zero max ends the cycle at once
    push(afm_pkg::FUNC_READ, 1, 1, 0, 0, 0);
    push(afm_pkg::FUNC_TICK, 0, 0, 0, 0, 2);
    idle_mode = 1;
    for (int k = 0; k < 300; k++) push_random();
    drain();

    // zero target, dev floor and min cells changed; long receiver hold-off
    set_regs(0, 0, 1, 3, 0);
    idle_mode = 2;
    for (int k = 0; k < 300; k++) push_random();
    hold_start = 1;
    drain();

    // 16-bit thresholds at their maximum, min cells changed at 400
    set_regs(65535, 65535, 65535, 65535, 400);
    idle_mode = 3;
    for (int k = 0; k < 250; k++) push_random();
    drain();

    set_regs(1000, 5, 3, 7, 2);
    idle_mode = 0;
    for (int k = 0; k < 230; k++) push_random();
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
